// ===== sv/db_gain_ramp_channel_router_core_assert.svh =====
// Assertion macros for the gain ramp channel router core
`ifndef DB_GAIN_RAMP_CHANNEL_ROUTER_CORE_ASSERT_SVH
`define DB_GAIN_RAMP_CHANNEL_ROUTER_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define DGR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DGR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dgr_pkg.sv =====
// Shared types, constants and table-building functions for the gain ramp core
package dgr_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int TABLE_DEPTH_DEF = 1024;

  localparam int LIN_W      = 18;
  localparam int DB_W       = 16;
  localparam int LEN_W      = 21;
  localparam int GAIN_W     = 24;
  localparam int STEP_W     = GAIN_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam int DB_TOP   = 1536;
  localparam int DB_RANGE = 32768;

  localparam logic [63:0] LOG_K = 64'd713378627;

  localparam logic signed [DB_W-1:0]   RST_TARGET_DB  = 16'sd0;
  localparam logic signed [GAIN_W-1:0] RST_CUR_GAIN   = -24'sd7864320;
  localparam logic [LEN_W-1:0]         RST_RAMP_LEN   = 21'd480;
  localparam logic signed [DB_W-1:0]   RST_ICOM_DB    = 16'sd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET,
    CFG_INITIAL,
    CFG_RAMP,
    CFG_CHAN,
    CFG_MIX,
    CFG_ICOM
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CH_LEFT,
    CH_RIGHT,
    CH_STEREO,
    CH_MIC
  } chan_mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_INIT,
    S_DIV,
    S_STEP,
    S_UPDATE,
    S_LUT_G,
    S_MUL_G,
    S_SCL_G,
    S_MUL_L,
    S_MUL_R,
    S_SCL_R,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    MSEL_GEN,
    MSEL_LEFT,
    MSEL_RIGHT
  } msel_t;

  typedef struct packed {
    logic  in_rdy;
    logic  div_init;
    logic  div_step;
    logic  step_ld;
    logic  gain_upd;
    logic  lut_gain;
    logic  mul_en;
    msel_t mul_sel;
    logic  scl_gen;
    logic  scl_left;
    logic  scl_right;
    logic  fin;
  } ctrl_t;

  typedef logic [63:0] root_arr_t [31];

  function automatic logic [63:0] int_sqrt(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] b;
    int i;
    x = x_in;
    r = '0;
    b = 64'd1 << 62;
    for (i = 0; i < 32; i++) begin
      if (b != '0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  // 2^(2^-k) in Q30, k = 0..30
  function automatic root_arr_t make_roots();
    root_arr_t rt;
    int i;
    rt[0] = 64'd2 << 30;
    for (i = 1; i <= 30; i++) begin
      rt[i] = int_sqrt(rt[i-1] << 30);
    end
    return rt;
  endfunction

  // Q2.16 linear gain of d (1/256 dB)
  function automatic logic [LIN_W-1:0] lin_of_db(input int d, input root_arr_t rt);
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] m;
    logic [63:0] r;
    int sh;
    int k;
    t = 64'(d + DB_RANGE) * LOG_K;
    u = t + (64'd32 << 40) - 64'(DB_RANGE) * LOG_K;
    n = u >> 40;
    f = (u >> 8) & 64'hFFFF_FFFF;
    m = 64'd1 << 30;
    for (k = 1; k <= 30; k++) begin
      if (f[32-k]) begin
        m = (m * rt[k]) >> 30;
      end
    end
    if (n > 64'd45) begin
      return '1;
    end
    sh = 46 - int'(n);
    r = (m + (64'd1 << (sh - 1))) >> sh;
    if (r > ((64'd1 << LIN_W) - 64'd1)) begin
      return '1;
    end
    return r[LIN_W-1:0];
  endfunction

endpackage

// ===== sv/dgr_rom.sv =====
// dB-to-linear lookup ROM with registered read
module dgr_rom #(
  parameter int TABLE_DEPTH = dgr_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
  output logic [dgr_pkg::LIN_W-1:0]      rd_data
);
  import dgr_pkg::*;

  localparam int SPACING = DB_RANGE / TABLE_DEPTH;

  typedef logic [LIN_W-1:0] rom_arr_t [TABLE_DEPTH];

  function automatic rom_arr_t build_rom();
    root_arr_t rt;
    rom_arr_t  tb;
    int i;
    rt = make_roots();
    for (i = 0; i < TABLE_DEPTH; i++) begin
      tb[i] = lin_of_db(DB_TOP - (TABLE_DEPTH - 1 - i) * SPACING, rt);
    end
    return tb;
  endfunction

  localparam rom_arr_t ROM = build_rom();

  logic [LIN_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    rd_data_r <= ROM[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/db_gain_ramp_channel_router_core.sv =====
// Gain ramp and channel router core: dB gain ramp, ROM lookup, scaling and stereo routing
//
// Channel  Dir  Handshake            Word
// cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
// in       in   in_valid/in_ready    in_gen_sample, in_left, in_right
// out      out  out_valid/out_ready  out_left, out_right
//
// One word at a time; microphone overwrite mode adds two more passes through the shared
// multiplier. The first word after a target write also runs the step divider, which makes
// one quotient bit per cycle (24 bits). Reset is synchronous, active low; the ROM is
// constant and needs no clearing. A result waiting in the output register lets the next
// word in; the core stalls in its final state only while that register is still full.
`include "db_gain_ramp_channel_router_core_assert.svh"

module db_gain_ramp_channel_router_core #(
  parameter int SAMPLE_BITS = dgr_pkg::SAMPLE_BITS_DEF,
  parameter int TABLE_DEPTH = dgr_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dgr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dgr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_BITS-1:0]     in_gen_sample,
  input  logic signed [SAMPLE_BITS-1:0]     in_left,
  input  logic signed [SAMPLE_BITS-1:0]     in_right,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]     out_left,
  output logic signed [SAMPLE_BITS-1:0]     out_right
);
  import dgr_pkg::*;

  localparam int AW        = $clog2(TABLE_DEPTH);
  localparam int SPACING   = DB_RANGE / TABLE_DEPTH;
  localparam int IDX_SH    = $clog2(SPACING) + 8;
  localparam int ENTRY0_DB = DB_TOP - (TABLE_DEPTH - 1) * SPACING;
  localparam int OFF0      = ENTRY0_DB * 256;
  localparam int GX_W      = GAIN_W + 2;
  localparam int PROD_W    = SAMPLE_BITS + LIN_W + 1;
  localparam int SH_W      = PROD_W - 16;
  localparam int DIV_STEPS = GAIN_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int FRAC_W    = GAIN_W - DB_W;

  // control and config state
  state_t                   state_r, state_nxt;
  ctrl_t                    ctrl;
  logic signed [DB_W-1:0]   tgt_db_r, tgt_db_nxt;
  logic [LEN_W-1:0]         ramp_len_r, ramp_len_nxt;
  chan_mode_t               chan_mode_r, chan_mode_nxt;
  logic                     mix_r, mix_nxt;
  logic signed [DB_W-1:0]   icom_db_r, icom_db_nxt;
  logic signed [GAIN_W-1:0] cur_r, cur_nxt;
  logic signed [STEP_W-1:0] step_r, step_nxt;
  logic                     ramp_up_r, ramp_up_nxt;
  logic                     pend_r, pend_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]         div_cnt_r, div_cnt_nxt;

  // payload
  logic signed [SAMPLE_BITS-1:0] gen_r, gen_nxt;
  logic signed [SAMPLE_BITS-1:0] left_r, left_nxt;
  logic signed [SAMPLE_BITS-1:0] right_r, right_nxt;
  logic signed [SAMPLE_BITS-1:0] s_r, s_nxt;
  logic signed [PROD_W-1:0]      prod_r, prod_nxt;
  logic [LEN_W-1:0]              div_rem_r, div_rem_nxt;
  logic [GAIN_W-1:0]             div_quo_r, div_quo_nxt;
  logic                          mag_nz_r, mag_nz_nxt;
  logic signed [SAMPLE_BITS-1:0] out_left_r, out_left_nxt;
  logic signed [SAMPLE_BITS-1:0] out_right_r, out_right_nxt;

  // datapath wires
  logic signed [GAIN_W-1:0]  tgt_g;
  logic signed [GAIN_W-1:0]  cfg_g;
  logic signed [GAIN_W:0]    diff;
  logic signed [GAIN_W:0]    diff_neg;
  logic [GAIN_W-1:0]         mag;
  logic [LEN_W-1:0]          len;
  logic [LEN_W:0]            rem_sh;
  logic [LEN_W:0]            rem_sub;
  logic                      div_ge;
  logic [GAIN_W-1:0]         q_sel;
  logic signed [GX_W-1:0]    upd_sum;
  logic signed [GX_W-1:0]    tgt_x;
  logic signed [GAIN_W-1:0]  upd_gain;
  logic signed [GAIN_W-1:0]  lut_g;
  logic [GX_W-1:0]           lut_off;
  logic [GX_W-1:0]           lut_idx;
  logic [AW-1:0]             rom_addr;
  logic [LIN_W-1:0]          rom_rd;
  logic signed [SAMPLE_BITS-1:0] mul_a;
  logic signed [LIN_W:0]     mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]         rnd;
  logic [SH_W-1:0]           shv;
  logic signed [SAMPLE_BITS-1:0] scl;
  logic [SAMPLE_BITS:0]      sum_l;
  logic [SAMPLE_BITS:0]      sum_r;
  logic signed [SAMPLE_BITS-1:0] sat_l;
  logic signed [SAMPLE_BITS-1:0] sat_r;
  logic signed [SAMPLE_BITS-1:0] res_l;
  logic signed [SAMPLE_BITS-1:0] res_r;
  logic                      in_acc;

  dgr_rom #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_rom (
    .clk     (clk),
    .rd_addr (rom_addr),
    .rd_data (rom_rd)
  );

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = pend_r ? S_DIV_INIT : S_UPDATE;
        end
      end
      S_DIV_INIT: state_nxt = S_DIV;
      S_DIV: begin
        if (div_cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_STEP;
        end
      end
      S_STEP:   state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_LUT_G;
      S_LUT_G:  state_nxt = S_MUL_G;
      S_MUL_G:  state_nxt = S_SCL_G;
      S_SCL_G:  state_nxt = (chan_mode_r == CH_MIC && !mix_r) ? S_MUL_L : S_FIN;
      S_MUL_L:  state_nxt = S_MUL_R;
      S_MUL_R:  state_nxt = S_SCL_R;
      S_SCL_R:  state_nxt = S_FIN;
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    ctrl = '0;
    ctrl.mul_sel = MSEL_GEN;
    unique case (state_r)
      S_IDLE:     ctrl.in_rdy = 1'b1;
      S_DIV_INIT: ctrl.div_init = 1'b1;
      S_DIV:      ctrl.div_step = 1'b1;
      S_STEP:     ctrl.step_ld = 1'b1;
      S_UPDATE:   ctrl.gain_upd = 1'b1;
      S_LUT_G:    ctrl.lut_gain = 1'b1;
      S_MUL_G: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MSEL_GEN;
      end
      S_SCL_G:    ctrl.scl_gen = 1'b1;
      S_MUL_L: begin
        ctrl.mul_en  = 1'b1;
        ctrl.mul_sel = MSEL_LEFT;
      end
      S_MUL_R: begin
        ctrl.mul_en   = 1'b1;
        ctrl.mul_sel  = MSEL_RIGHT;
        ctrl.scl_left = 1'b1;
      end
      S_SCL_R:    ctrl.scl_right = 1'b1;
      S_FIN:      ctrl.fin = !out_valid_r || out_ready;
      default:    ctrl.in_rdy = 1'b0;
    endcase
  end

  assign in_ready  = ctrl.in_rdy && rst_n;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = rst_n;

  // step divider
  assign tgt_g    = {tgt_db_r, {FRAC_W{1'b0}}};
  assign cfg_g    = {cfg_data[DB_W-1:0], {FRAC_W{1'b0}}};
  assign diff     = $signed({tgt_g[GAIN_W-1], tgt_g}) - $signed({cur_r[GAIN_W-1], cur_r});
  assign diff_neg = -diff;
  assign mag      = diff[GAIN_W] ? diff_neg[GAIN_W-1:0] : diff[GAIN_W-1:0];
  assign len      = (ramp_len_r == '0) ? LEN_W'(1) : ramp_len_r;
  assign rem_sh   = {div_rem_r, div_quo_r[GAIN_W-1]};
  assign div_ge   = rem_sh >= {1'b0, len};
  assign rem_sub  = rem_sh - {1'b0, len};
  assign q_sel    = (div_quo_r == '0 && mag_nz_r) ? GAIN_W'(1) : div_quo_r;

  // gain update, clamped at the target
  assign upd_sum  = $signed({{2{cur_r[GAIN_W-1]}}, cur_r}) + $signed({step_r[STEP_W-1], step_r});
  assign tgt_x    = $signed({{2{tgt_g[GAIN_W-1]}}, tgt_g});
  always_comb begin
    if (ramp_up_r) begin
      upd_gain = (upd_sum < tgt_x) ? upd_sum[GAIN_W-1:0] : tgt_g;
    end else begin
      upd_gain = (upd_sum > tgt_x) ? upd_sum[GAIN_W-1:0] : tgt_g;
    end
  end

  // ROM index: nearest entry, saturated to the table
  assign lut_g   = ctrl.lut_gain ? cur_r : $signed({icom_db_r, {FRAC_W{1'b0}}});
  assign lut_off = {{2{lut_g[GAIN_W-1]}}, lut_g} - GX_W'(OFF0);
  assign lut_idx = (lut_off + GX_W'(SPACING * 128)) >> IDX_SH;
  always_comb begin
    if (lut_off[GX_W-1]) begin
      rom_addr = '0;
    end else if (lut_idx > GX_W'(TABLE_DEPTH - 1)) begin
      rom_addr = AW'(TABLE_DEPTH - 1);
    end else begin
      rom_addr = lut_idx[AW-1:0];
    end
  end

  // shared multiplier and rounding/saturation
  always_comb begin
    case (ctrl.mul_sel)
      MSEL_LEFT:  mul_a = left_r;
      MSEL_RIGHT: mul_a = right_r;
      default:    mul_a = gen_r;
    endcase
  end

  assign mul_b = $signed({1'b0, rom_rd});
  assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign rnd   = prod_r + PROD_W'(32768);
  assign shv   = rnd[PROD_W-1:16];

  always_comb begin
    if ((&shv[SH_W-1:SAMPLE_BITS-1]) || !(|shv[SH_W-1:SAMPLE_BITS-1])) begin
      scl = shv[SAMPLE_BITS-1:0];
    end else begin
      scl = {shv[SH_W-1], {(SAMPLE_BITS-1){~shv[SH_W-1]}}};
    end
  end

  // routing
  assign sum_l = {left_r[SAMPLE_BITS-1], left_r} + {s_r[SAMPLE_BITS-1], s_r};
  assign sum_r = {right_r[SAMPLE_BITS-1], right_r} + {s_r[SAMPLE_BITS-1], s_r};
  assign sat_l = (sum_l[SAMPLE_BITS] == sum_l[SAMPLE_BITS-1]) ? sum_l[SAMPLE_BITS-1:0] :
                 {sum_l[SAMPLE_BITS], {(SAMPLE_BITS-1){~sum_l[SAMPLE_BITS]}}};
  assign sat_r = (sum_r[SAMPLE_BITS] == sum_r[SAMPLE_BITS-1]) ? sum_r[SAMPLE_BITS-1:0] :
                 {sum_r[SAMPLE_BITS], {(SAMPLE_BITS-1){~sum_r[SAMPLE_BITS]}}};

  always_comb begin
    res_l = left_r;
    res_r = right_r;
    if (!mix_r) begin
      case (chan_mode_r)
        CH_LEFT: begin
          res_l = s_r;
          res_r = '0;
        end
        CH_RIGHT: begin
          res_l = '0;
          res_r = s_r;
        end
        CH_STEREO: begin
          res_l = s_r;
          res_r = s_r;
        end
        default: begin
          res_l = left_r;
          res_r = right_r;
        end
      endcase
    end else begin
      case (chan_mode_r)
        CH_LEFT:   res_l = sat_l;
        CH_RIGHT:  res_r = sat_r;
        CH_STEREO: begin
          res_l = sat_l;
          res_r = sat_r;
        end
        default:   res_l = left_r;
      endcase
    end
  end

  // next values
  always_comb begin
    tgt_db_nxt    = tgt_db_r;
    ramp_len_nxt  = ramp_len_r;
    chan_mode_nxt = chan_mode_r;
    mix_nxt       = mix_r;
    icom_db_nxt   = icom_db_r;
    cur_nxt       = cur_r;
    step_nxt      = step_r;
    ramp_up_nxt   = ramp_up_r;
    pend_nxt      = pend_r;
    div_cnt_nxt   = div_cnt_r;
    div_rem_nxt   = div_rem_r;
    div_quo_nxt   = div_quo_r;
    mag_nz_nxt    = mag_nz_r;
    gen_nxt       = gen_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    s_nxt         = s_r;
    prod_nxt      = prod_r;
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (in_acc) begin
      gen_nxt   = in_gen_sample;
      left_nxt  = in_left;
      right_nxt = in_right;
    end
    if (ctrl.div_init) begin
      div_rem_nxt = '0;
      div_quo_nxt = mag;
      mag_nz_nxt  = |mag;
      div_cnt_nxt = '0;
    end
    if (ctrl.div_step) begin
      div_rem_nxt = div_ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
      div_quo_nxt = {div_quo_r[GAIN_W-2:0], div_ge};
      div_cnt_nxt = div_cnt_r + CNT_W'(1);
    end
    if (ctrl.step_ld) begin
      step_nxt = ramp_up_r ? $signed({1'b0, q_sel}) : -$signed({1'b0, q_sel});
      pend_nxt = 1'b0;
    end
    if (ctrl.gain_upd) begin
      cur_nxt = upd_gain;
    end
    if (ctrl.mul_en) begin
      prod_nxt = prod;
    end
    if (ctrl.scl_gen) begin
      s_nxt = scl;
    end
    if (ctrl.scl_left) begin
      left_nxt = scl;
    end
    if (ctrl.scl_right) begin
      right_nxt = scl;
    end
    if (ctrl.fin) begin
      out_left_nxt  = res_l;
      out_right_nxt = res_r;
      out_valid_nxt = 1'b1;
    end

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TARGET: begin
          tgt_db_nxt  = cfg_data[DB_W-1:0];
          ramp_up_nxt = cur_r < cfg_g;
          pend_nxt    = 1'b1;
        end
        CFG_INITIAL: cur_nxt       = cfg_g;
        CFG_RAMP:    ramp_len_nxt  = cfg_data[LEN_W-1:0];
        CFG_CHAN:    chan_mode_nxt = chan_mode_t'(cfg_data[1:0]);
        CFG_MIX:     mix_nxt       = cfg_data[0];
        CFG_ICOM:    icom_db_nxt   = cfg_data[DB_W-1:0];
        default:     pend_nxt      = pend_nxt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tgt_db_r    <= RST_TARGET_DB;
      ramp_len_r  <= RST_RAMP_LEN;
      chan_mode_r <= CH_LEFT;
      mix_r       <= 1'b0;
      icom_db_r   <= RST_ICOM_DB;
      cur_r       <= RST_CUR_GAIN;
      step_r      <= '0;
      ramp_up_r   <= 1'b0;
      pend_r      <= 1'b1;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      tgt_db_r    <= tgt_db_nxt;
      ramp_len_r  <= ramp_len_nxt;
      chan_mode_r <= chan_mode_nxt;
      mix_r       <= mix_nxt;
      icom_db_r   <= icom_db_nxt;
      cur_r       <= cur_nxt;
      step_r      <= step_nxt;
      ramp_up_r   <= ramp_up_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      div_cnt_r   <= div_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    gen_r       <= gen_nxt;
    left_r      <= left_nxt;
    right_r     <= right_nxt;
    s_r         <= s_nxt;
    prod_r      <= prod_nxt;
    div_rem_r   <= div_rem_nxt;
    div_quo_r   <= div_quo_nxt;
    mag_nz_r    <= mag_nz_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;

  `DGR_ASSERT_SAME(a_div_cnt_range, state_r == S_DIV, div_cnt_r < CNT_W'(DIV_STEPS), "divider count past last quotient bit")
  `DGR_ASSERT_NEXT(a_step_clears_pending, state_r == S_STEP && !cfg_valid, !pend_r, "step loaded but still pending")
  `DGR_ASSERT_NEXT(a_gain_clamped, state_r == S_UPDATE && !cfg_valid, $past(ramp_up_r) ? (cur_r <= $past(tgt_g)) : (cur_r >= $past(tgt_g)), "gain moved past target")
  `DGR_ASSERT_SAME(a_out_from_fin, $rose(out_valid_r), $past(state_r == S_FIN), "result loaded outside final state")

endmodule
